// ----- design/rrtt_pkg.sv -----
// Package for the round-robin task table: sizes, mode and status codes,
// beat types and the controller/datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps

package rrtt_pkg;

    localparam int TASK_SLOTS   = 16;
    localparam int SLOT_CAP     = 16;
    localparam int SLOT_CNT     = (TASK_SLOTS < SLOT_CAP) ?
                                  ((TASK_SLOTS < 1) ? 1 : TASK_SLOTS) : SLOT_CAP;
    localparam int SLOT_W       = (SLOT_CNT > 1) ? $clog2(SLOT_CNT) : 1;
    localparam int SLOT_FIELD_W = 4;

    localparam logic [15:0] MIN_STACK_RESET = 16'd256;

    localparam logic [2:0] MODE_CLEAR  = 3'd0;
    localparam logic [2:0] MODE_CREATE = 3'd1;
    localparam logic [2:0] MODE_SCHED  = 3'd2;
    localparam logic [2:0] MODE_SETCUR = 3'd3;
    localparam logic [2:0] MODE_SETNXT = 3'd4;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_NULL  = 3'd1;
    localparam logic [2:0] ST_SMALL = 3'd2;
    localparam logic [2:0] ST_FULL  = 3'd3;
    localparam logic [2:0] ST_NONE  = 3'd4;

    typedef struct packed {
        logic [2:0]              mode;
        logic [31:0]             tcb_handle;
        logic [15:0]             stack_size;
        logic [SLOT_FIELD_W-1:0] target_slot;
    } t_in_item;

    typedef struct packed {
        logic [2:0]              status;
        logic [SLOT_FIELD_W-1:0] task_slot;
        logic [31:0]             task_handle;
        logic [SLOT_FIELD_W-1:0] current_slot;
        logic [SLOT_FIELD_W-1:0] next_slot;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic       load;          // capture input beat, init scan
        logic       res_plain;     // result = res_status, slot/handle zero
        logic [2:0] res_status;
        logic       clear;
        logic       set_cur;
        logic       set_nxt;
        logic       scan_step;
        logic       create_commit; // claim slot at scan index
        logic       sched_hit;     // choose slot at scan index, read handle
        logic       out_load;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] mode;
        logic       null_handle;
        logic       stack_small;
        logic       scan_hit;
        logic       scan_last;
        logic       out_blocked;
    } t_dp_sts;

endpackage

// ----- design/round_robin_task_table_core.sv -----
// Top level of the round-robin task table: controller plus datapath.
// Depends on rrtt_pkg, rrtt_ctrl, rrtt_datapath.
`timescale 1ns / 1ps
//
// Usage:
//   Request channel i_in_valid / o_in_stall / i_in carries one request beat
//   (mode, handle, stack size, target slot). Result channel o_out_valid /
//   i_out_stall / o_out returns exactly one result beat per request.
//   Config channel i_cfg_valid / o_cfg_ready / i_cfg_data writes the minimum
//   stack size; ready is always high. Write it only while the block is idle.
// Timing:
//   A beat is taken in the idle state, decoded in the next cycle, and for
//   create and schedule the table is scanned one slot per cycle, over at most
//   SLOT_CNT slots. No new request is taken before the previous one leaves the
//   emit state; the result is valid the cycle after the emit cycle. The next
//   beat is taken while a result waits
//   in the output register; only the following result waits for it.
// Reset:
//   Synchronous, active low. All slots free, current and next slot zero,
//   minimum stack size 256, no result pending. Handle storage is not cleared.
// Stall:
//   A stalled result holds in the output register; processing of the next
//   request stops before its result would overwrite it.

module round_robin_task_table_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rrtt_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rrtt_pkg::t_out_item o_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [15:0]         i_cfg_data
);
    import rrtt_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    assign o_cfg_ready = 1'b1;

    rrtt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    rrtt_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

// ----- design/rrtt_datapath.sv -----
// Datapath of the round-robin task table: slot occupancy, handle memory,
// slot registers, scan pointer, result and output registers.
// Depends on rrtt_pkg.
`timescale 1ns / 1ps

module rrtt_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rrtt_pkg::t_in_item i_in,
    input  logic               i_cfg_valid,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_out_stall,
    input  rrtt_pkg::t_dp_cmd  i_cmd,
    output rrtt_pkg::t_dp_sts  o_sts,
    output logic               o_out_valid,
    output rrtt_pkg::t_out_item o_out
);
    import rrtt_pkg::*;

    logic [15:0]             r_min_stack;
    logic [SLOT_CNT-1:0]     r_occ;
    logic [SLOT_W-1:0]       r_running;
    logic [SLOT_W-1:0]       r_chosen;
    logic [SLOT_W-1:0]       r_scan_idx;
    logic [SLOT_W-1:0]       r_scan_cnt;
    t_in_item                r_item;
    logic [2:0]              r_res_status;
    logic [SLOT_FIELD_W-1:0] r_res_slot;
    logic [31:0]             r_res_handle;
    logic                    r_res_use_mem;
    logic [31:0]             r_mem [SLOT_CNT];
    logic [31:0]             r_rd_data;
    logic                    r_out_valid;
    t_out_item               r_out;

    logic [SLOT_W-1:0]       n_scan_idx;
    logic [SLOT_W-1:0]       n_start_idx;
    logic                    w_target_ok;

    function automatic logic [SLOT_W-1:0] wrap_inc(input logic [SLOT_W-1:0] s);
        wrap_inc = (s == SLOT_W'(SLOT_CNT - 1)) ? '0 : s + 1'b1;
    endfunction

    assign n_start_idx = (i_in.mode == MODE_SCHED) ? wrap_inc(r_running) : '0;
    assign n_scan_idx  = wrap_inc(r_scan_idx);
    assign w_target_ok = {1'b0, r_item.target_slot} < (SLOT_FIELD_W + 1)'(SLOT_CNT);

    assign o_sts.mode        = r_item.mode;
    assign o_sts.null_handle = (r_item.tcb_handle == 32'd0);
    assign o_sts.stack_small = (r_item.stack_size < r_min_stack);
    // create looks for a free slot, schedule for an occupied one
    assign o_sts.scan_hit    = (r_item.mode == MODE_CREATE) ? !r_occ[r_scan_idx]
                                                            : r_occ[r_scan_idx];
    assign o_sts.scan_last   = (r_scan_cnt == SLOT_W'(SLOT_CNT - 1));
    assign o_sts.out_blocked = r_out_valid && i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_stack <= MIN_STACK_RESET;
            r_occ       <= '0;
            r_running   <= '0;
            r_chosen    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_min_stack <= i_cfg_data;
            end
            if (i_cmd.clear) begin
                r_occ <= '0;
            end else if (i_cmd.create_commit) begin
                r_occ[r_scan_idx] <= 1'b1;
            end
            if (i_cmd.set_cur && w_target_ok) begin
                r_running <= SLOT_W'(r_item.target_slot);
            end
            if (i_cmd.sched_hit) begin
                r_chosen <= r_scan_idx;
            end else if (i_cmd.set_nxt && w_target_ok) begin
                r_chosen <= SLOT_W'(r_item.target_slot);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item     <= i_in;
            r_scan_idx <= n_start_idx;
            r_scan_cnt <= '0;
        end else if (i_cmd.scan_step) begin
            r_scan_idx <= n_scan_idx;
            r_scan_cnt <= r_scan_cnt + 1'b1;
        end

        if (i_cmd.res_plain) begin
            r_res_status  <= i_cmd.res_status;
            r_res_slot    <= '0;
            r_res_handle  <= '0;
            r_res_use_mem <= 1'b0;
        end else if (i_cmd.create_commit) begin
            r_res_status  <= ST_OK;
            r_res_slot    <= SLOT_FIELD_W'(r_scan_idx);
            r_res_handle  <= r_item.tcb_handle;
            r_res_use_mem <= 1'b0;
        end else if (i_cmd.sched_hit) begin
            r_res_status  <= ST_OK;
            r_res_slot    <= SLOT_FIELD_W'(r_scan_idx);
            r_res_handle  <= '0;
            r_res_use_mem <= 1'b1;
        end

        if (i_cmd.out_load) begin
            r_out.status       <= r_res_status;
            r_out.task_slot    <= r_res_slot;
            r_out.task_handle  <= r_res_use_mem ? r_rd_data : r_res_handle;
            r_out.current_slot <= SLOT_FIELD_W'(r_running);
            r_out.next_slot    <= SLOT_FIELD_W'(r_chosen);
        end
    end

    // handle memory: one write port (create), one registered read (schedule)
    always_ff @(posedge i_clk) begin
        if (i_cmd.create_commit) begin
            r_mem[r_scan_idx] <= r_item.tcb_handle;
        end
        if (i_cmd.sched_hit) begin
            r_rd_data <= r_mem[r_scan_idx];
        end
    end

    a_create_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.create_commit |=> r_occ[$past(r_scan_idx)])
        else $error("created slot not marked occupied");

    a_sched_chosen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sched_hit |=> (r_chosen == $past(r_scan_idx)))
        else $error("scheduled slot not loaded into chosen register");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.out_load && r_out_valid && i_out_stall))
        else $error("output register overwritten while stalled");

endmodule

// ----- design/rrtt_ctrl.sv -----
// Controller of the round-robin task table: decodes the request mode and
// sequences the one-slot-per-cycle scan and the output load.
// Depends on rrtt_pkg.
`timescale 1ns / 1ps

module rrtt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  rrtt_pkg::t_dp_sts i_sts,
    output rrtt_pkg::t_dp_cmd o_cmd
);
    import rrtt_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state          = S_EMIT;
                o_cmd.res_plain  = 1'b1;
                o_cmd.res_status = ST_OK;
                case (i_sts.mode)
                    MODE_CLEAR: begin
                        o_cmd.clear = 1'b1;
                    end
                    MODE_CREATE: begin
                        if (i_sts.null_handle) begin
                            o_cmd.res_status = ST_NULL;
                        end else if (i_sts.stack_small) begin
                            o_cmd.res_status = ST_SMALL;
                        end else begin
                            o_cmd.res_plain = 1'b0;
                            n_state         = S_SCAN;
                        end
                    end
                    MODE_SCHED: begin
                        o_cmd.res_plain = 1'b0;
                        n_state         = S_SCAN;
                    end
                    MODE_SETCUR: begin
                        o_cmd.set_cur = 1'b1;
                    end
                    MODE_SETNXT: begin
                        o_cmd.set_nxt = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            S_SCAN: begin
                if (i_sts.scan_hit) begin
                    if (i_sts.mode == MODE_CREATE) begin
                        o_cmd.create_commit = 1'b1;
                    end else begin
                        o_cmd.sched_hit = 1'b1;
                    end
                    n_state = S_EMIT;
                end else if (i_sts.scan_last) begin
                    o_cmd.res_plain  = 1'b1;
                    o_cmd.res_status = (i_sts.mode == MODE_CREATE) ? ST_FULL : ST_NONE;
                    n_state          = S_EMIT;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_EMIT: begin
                if (!i_sts.out_blocked) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && i_sts.scan_last) |=> (r_state == S_EMIT))
        else $error("scan ran past the last slot");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_EXEC))
        else $error("captured beat not decoded");

    a_emit_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (r_state == S_IDLE))
        else $error("result loaded but controller did not return to idle");

endmodule

// ----- tb/sv/tb.sv -----
// Testbench for round_robin_task_table_core: random and directed request beats,
// a local model of the slot table, and per-field result checks.
// Depends on rrtt_pkg and the round_robin_task_table_core RTL.
`timescale 1ns / 1ps

module tb;
    import rrtt_pkg::*;

    localparam logic [2:0] MODE_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] MODE_UNUSED_LAST  = 3'd7;
    localparam int LIMIT_CYCLES  = 500000;
    localparam int TAIL_CYCLES   = 2 * (3 + SLOT_CNT);
    localparam int HOLD_CYCLES   = 300;
    localparam int ITEMS_PER_SET = 275;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in        = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data  = '0;

    round_robin_task_table_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // model of the slot table
    logic [SLOT_CNT-1:0]     slot_busy = '0;
    logic [31:0]             slot_tcb [SLOT_CNT];
    logic [SLOT_FIELD_W-1:0] run_slot  = '0;
    logic [SLOT_FIELD_W-1:0] pick_slot = '0;
    logic [15:0]             min_stack = MIN_STACK_RESET;

    t_in_item  req_q [$];
    t_out_item want_q [$];
    bit        in_took;
    int        mismatches   = 0;
    int        cycle_cnt    = 0;
    int        snd_idle_pct = 0;
    int        rcv_idle_pct = 0;
    int        hold_reqs    = 0;
    int        hold_seen    = 0;
    int        hold_left    = 0;
    logic [15:0] cfg_min    = MIN_STACK_RESET;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_out_item table_step(t_in_item req);
        t_out_item res;
        int        pos;
        bit        found;
        res   = '0;
        found = 1'b0;
        res.status = ST_OK;
        case (req.mode)
            MODE_CLEAR: slot_busy = '0;
            MODE_CREATE: begin
                if (req.tcb_handle == 32'd0) begin
                    res.status = ST_NULL;
                end else if (req.stack_size < min_stack) begin
                    res.status = ST_SMALL;
                end else begin
                    res.status = ST_FULL;
                    for (int i = 0; i < SLOT_CNT; i++) begin
                        if (!found && !slot_busy[i]) begin
                            found          = 1'b1;
                            slot_busy[i]   = 1'b1;
                            slot_tcb[i]    = req.tcb_handle;
                            res.status     = ST_OK;
                            res.task_slot  = SLOT_FIELD_W'(i);
                            res.task_handle = req.tcb_handle;
                        end
                    end
                end
            end
            MODE_SCHED: begin
                // scan starts one past the running slot and ends on it
                pos = int'(run_slot);
                res.status = ST_NONE;
                for (int i = 0; i < SLOT_CNT; i++) begin
                    pos = (pos + 1) % SLOT_CNT;
                    if (!found && slot_busy[pos]) begin
                        found           = 1'b1;
                        pick_slot       = SLOT_FIELD_W'(pos);
                        res.status      = ST_OK;
                        res.task_slot   = SLOT_FIELD_W'(pos);
                        res.task_handle = slot_tcb[pos];
                    end
                end
            end
            MODE_SETCUR: if (req.target_slot < SLOT_CNT) run_slot = req.target_slot;
            MODE_SETNXT: if (req.target_slot < SLOT_CNT) pick_slot = req.target_slot;
            default: ;
        endcase
        res.current_slot = run_slot;
        res.next_slot    = pick_slot;
        return res;
    endfunction

    function automatic t_in_item mk_req(logic [2:0] m, logic [31:0] h, logic [15:0] s,
                                        logic [3:0] t);
        t_in_item r;
        r.mode        = m;
        r.tcb_handle  = h;
        r.stack_size  = s;
        r.target_slot = t;
        return r;
    endfunction

    function automatic t_in_item rand_req(logic [15:0] min_ok);
        t_in_item r;
        int       pick;
        r    = mk_req(MODE_SCHED, $urandom(), 16'($urandom_range(0, 65535)),
                      4'($urandom_range(0, 15)));
        pick = int'($urandom_range(0, 99));
        if (pick < 3) begin
            r.mode = MODE_CLEAR;
        end else if (pick < 47) begin
            r.mode = MODE_CREATE;
            case ($urandom_range(0, 9))
                0:       r.tcb_handle = '0;
                1:       r.tcb_handle = '1;
                2:       r.tcb_handle = 32'($urandom_range(1, 4));   // duplicates
                default: ;
            endcase
            case ($urandom_range(0, 5))
                0, 1:    ;
                2:       r.stack_size = min_ok;
                3:       r.stack_size = min_ok - 16'd1;
                default: r.stack_size = 16'($urandom_range(min_ok, 65535));
            endcase
        end else if (pick < 80) begin
            r.mode = MODE_SCHED;
        end else if (pick < 88) begin
            r.mode = MODE_SETCUR;
        end else if (pick < 95) begin
            r.mode = MODE_SETNXT;
        end else begin
            r.mode = 3'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
        end
        return r;
    endfunction

    task automatic flag_field(string name, logic [31:0] want, logic [31:0] got);
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        mismatches++;
    endtask

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_took) begin
            if (req_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
                i_in       <= req_q.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result-side stall, with an occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
        end
    end

    // monitor: predict on each accepted request beat, check each result beat
    always @(posedge i_clk) begin
        t_out_item want;
        in_took = i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                min_stack = i_cfg_data;
            if (in_took)
                want_q.push_back(table_step(i_in));
            if (o_out_valid && !i_out_stall) begin
                if (want_q.size() == 0) begin
                    $display("%0t: result beat with none expected, got %p", $time, o_out);
                    mismatches++;
                end else begin
                    want = want_q.pop_front();
                    if (o_out.status !== want.status)
                        flag_field("status", 32'(want.status), 32'(o_out.status));
                    if (o_out.task_slot !== want.task_slot)
                        flag_field("task_slot", 32'(want.task_slot),
                                   32'(o_out.task_slot));
                    if (o_out.task_handle !== want.task_handle)
                        flag_field("task_handle", want.task_handle, o_out.task_handle);
                    if (o_out.current_slot !== want.current_slot)
                        flag_field("current_slot", 32'(want.current_slot),
                                   32'(o_out.current_slot));
                    if (o_out.next_slot !== want.next_slot)
                        flag_field("next_slot", 32'(want.next_slot),
                                   32'(o_out.next_slot));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("[round_robin_task_table_core] ERROR");
            $finish;
        end
    end

    task automatic drain();
        do begin
            @(negedge i_clk);
            #1;
        end while (req_q.size() != 0 || i_in_valid || want_q.size() != 0);
    endtask

    task automatic write_min_stack(logic [15:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cfg_min = v;
    endtask

    initial begin
        logic [15:0] min_plan [6];
        min_plan[0] = 16'd0;
        min_plan[1] = 16'hFFFF;
        min_plan[2] = 16'($urandom_range(0, 65535));
        min_plan[3] = 16'd1;
        min_plan[4] = MIN_STACK_RESET;
        min_plan[5] = 16'($urandom_range(0, 4096));

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        snd_idle_pct = 32;
        rcv_idle_pct = 45;

        // directed: empty schedule, reject order, fill to full, wrap, odd modes, clear
        req_q.push_back(mk_req(MODE_SCHED, '0, '0, '0));
        req_q.push_back(mk_req(MODE_CREATE, '0, '0, '0));
        req_q.push_back(mk_req(MODE_CREATE, 32'd5, MIN_STACK_RESET - 16'd1, '0));
        req_q.push_back(mk_req(MODE_CREATE, '1, MIN_STACK_RESET, '0));
        repeat (SLOT_CNT) req_q.push_back(mk_req(MODE_CREATE, 32'd1, 16'hFFFF, '1));
        req_q.push_back(mk_req(MODE_SETCUR, '0, '0, 4'd15));
        req_q.push_back(mk_req(MODE_SETNXT, '1, '1, 4'd0));
        req_q.push_back(mk_req(MODE_SCHED, '0, '0, '0));
        for (int m = MODE_UNUSED_FIRST; m <= MODE_UNUSED_LAST; m++)
            req_q.push_back(mk_req(3'(m), $urandom(), 16'($urandom()), 4'($urandom())));
        req_q.push_back(mk_req(MODE_CLEAR, '0, '0, '0));
        req_q.push_back(mk_req(MODE_SCHED, '0, '0, '0));

        for (int ph = 0; ph < 6; ph++) begin
            drain();
            write_min_stack(min_plan[ph]);
            if (ph < 2) begin
                snd_idle_pct = 32;
                rcv_idle_pct = 45;
            end else if (ph < 4) begin
                snd_idle_pct = 45;
                rcv_idle_pct = 32;
            end else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            // long result hold-off while requests keep coming
            if (ph == 4)
                hold_reqs++;
            repeat (ITEMS_PER_SET) req_q.push_back(rand_req(cfg_min));
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && want_q.size() == 0) begin
            $display("[round_robin_task_table_core] OK");
        end else begin
            $display("[round_robin_task_table_core] ERROR");
        end
        $finish;
    end

endmodule
